FILE: hdl/utd_pkg.sv
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 decoder package
// Shared types, constants and the result helper used by the decoder files.
// ----------------------------------------------------------------------------
`default_nettype none

package utd_pkg;

  // Replacement character for every malformed or unsupported input.
  localparam logic [15:0] REPL_UNIT = 16'hFFFD;

  // Lead byte ranges.
  localparam logic [7:0] ASCII_TOP = 8'h7F;
  localparam logic [7:0] LEAD2_LO  = 8'hC2;
  localparam logic [7:0] LEAD2_HI  = 8'hDF;
  localparam logic [7:0] LEAD3_LO  = 8'hE0;
  localparam logic [7:0] LEAD3_HI  = 8'hEF;
  localparam logic [7:0] LEAD4_LO  = 8'hF0;
  localparam logic [7:0] LEAD4_HI  = 8'hF4;

  // Leads that narrow the range of the second byte.
  localparam logic [7:0] LEAD_E0 = 8'hE0;
  localparam logic [7:0] LEAD_ED = 8'hED;
  localparam logic [7:0] LEAD_F0 = 8'hF0;
  localparam logic [7:0] LEAD_F4 = 8'hF4;

  // Continuation byte limits.
  localparam logic [7:0] CONT_LO    = 8'h80;
  localparam logic [7:0] CONT_HI    = 8'hBF;
  localparam logic [7:0] E0_CONT_LO = 8'hA0;
  localparam logic [7:0] ED_CONT_HI = 8'h9F;
  localparam logic [7:0] F0_CONT_LO = 8'h90;
  localparam logic [7:0] F4_CONT_HI = 8'h8F;

  // Sequence lengths.
  localparam logic [2:0] LEN_NONE = 3'd0;
  localparam logic [2:0] LEN_TWO  = 3'd2;
  localparam logic [2:0] LEN_THR  = 3'd3;
  localparam logic [2:0] LEN_FOUR = 3'd4;

  // Output queue geometry: room for two full results pairs.
  localparam int unsigned OUT_DEPTH = 4;
  localparam int unsigned OUT_PTR_W = 2;
  localparam int unsigned OUT_CNT_W = 3;

  // Decoder state carried from byte to byte.
  typedef struct packed {
    logic [2:0]  seq_len;
    logic [1:0]  taken;
    logic [20:0] accum;
    logic [7:0]  nxt_lo;
    logic [7:0]  nxt_hi;
  } dec_state_t;

  localparam dec_state_t STATE_IDLE = '{
    seq_len: LEN_NONE,
    taken:   2'd0,
    accum:   21'd0,
    nxt_lo:  CONT_LO,
    nxt_hi:  CONT_HI
  };

  // Up to two code units produced by one byte.
  typedef struct packed {
    logic [1:0]  count;
    logic [15:0] unit0;
    logic [15:0] unit1;
  } dec_result_t;

  // One entry of the output queue.
  typedef struct packed {
    logic        text_end;
    logic        run_last;
    logic [15:0] unit;
  } out_entry_t;

  // Appends a code unit to the result pair.
  function automatic dec_result_t push_unit(dec_result_t r, logic [15:0] u);
    dec_result_t n;
    n = r;
    if (r.count == 2'd0) begin
      n.unit0 = u;
    end else begin
      n.unit1 = u;
    end
    n.count = r.count + 2'd1;
    return n;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/utf8_to_utf16_validating_decoder.sv
// Throughput: one byte per cycle while the output queue has room; a byte
// that yields two code units takes two output beats, and the four-entry
// output queue absorbs the extra unit. An accepted byte is held in the
// input register, released only when the queue has room for two units.
// Reset (rst_ni low, asynchronous) closes any open sequence and empties the
// input register and the output queue.
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 validating decoder
// Streams UTF-8 bytes in and UTF-16 code units out, replacing malformed
// input with U+FFFD.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_to_utf16_validating_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
  input  logic        s_axis_tlast,  // text_last
  // Output stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // [15:0] code_unit
  output logic        m_axis_tuser,  // run_last
  output logic        m_axis_tlast   // text_end
);
  import utd_pkg::*;

  logic                 in_vld_q, in_vld_d;
  logic [7:0]           in_byte_q;
  logic                 in_last_q;
  logic                 s_beat;
  logic                 advance;
  dec_state_t           state_q, state_d;
  dec_result_t          res;
  out_entry_t           queue_q [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [OUT_CNT_W-1:0] count_q, count_d;
  logic [1:0]           push_n;
  logic                 pop;
  out_entry_t           entry0, entry1;
  out_entry_t           head;

  // Input register handshake.
  assign advance       = in_vld_q && (count_q <= OUT_CNT_W'(OUT_DEPTH - 2));
  assign s_axis_tready = !in_vld_q || advance;
  assign s_beat        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_vld_d = in_vld_q;
    if (s_beat) begin
      in_vld_d = 1'b1;
    end else if (advance) begin
      in_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_beat) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  // Decode of the registered byte.
  utd_step u_step (
    .state_i (state_q),
    .byte_i  (in_byte_q),
    .last_i  (in_last_q),
    .state_o (state_d),
    .res_o   (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= STATE_IDLE;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // Queue entries: the final unit of a byte carries the run and text marks.
  assign entry0 = '{text_end: (res.count == 2'd1) && in_last_q,
                    run_last: (res.count == 2'd1),
                    unit:     res.unit0};
  assign entry1 = '{text_end: in_last_q, run_last: 1'b1, unit: res.unit1};

  assign push_n  = advance ? res.count : 2'd0;
  assign pop     = m_axis_tvalid && m_axis_tready;
  assign count_d = count_q + OUT_CNT_W'(push_n) - OUT_CNT_W'(pop);

  // Output queue storage.
  always_ff @(posedge clk_i) begin
    if (push_n != 2'd0) begin
      queue_q[wr_ptr_q] <= entry0;
    end
    if (push_n == 2'd2) begin
      queue_q[wr_ptr_q + OUT_PTR_W'(1)] <= entry1;
    end
  end

  // Output queue pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + OUT_PTR_W'(push_n);
      rd_ptr_q <= rd_ptr_q + OUT_PTR_W'(pop);
      count_q  <= count_d;
    end
  end

  // Output beat from the queue head.
  assign head          = queue_q[rd_ptr_q];
  assign m_axis_tvalid = (count_q != '0);
  assign m_axis_tdata  = head.unit;
  assign m_axis_tuser  = head.run_last;
  assign m_axis_tlast  = head.text_end;

endmodule

`default_nettype wire

FILE: hdl/utd_step.sv
// ----------------------------------------------------------------------------
// UTF-8 decoder step
// Combinational decode of one byte against the current sequence state,
// giving the next state and up to two UTF-16 code units.
// ----------------------------------------------------------------------------
`default_nettype none

module utd_step (
  input  utd_pkg::dec_state_t  state_i,
  input  logic [7:0]           byte_i,
  input  logic                 last_i,
  output utd_pkg::dec_state_t  state_o,
  output utd_pkg::dec_result_t res_o
);
  import utd_pkg::*;

  logic        mismatch;
  logic        as_lead;
  logic [1:0]  taken_inc;
  logic [20:0] accum_inc;
  logic        complete;
  dec_state_t  nxt;
  dec_result_t res;

  // A byte outside the allowed window breaks the open sequence.
  assign mismatch  = (state_i.seq_len != LEN_NONE) &&
                     ((byte_i < state_i.nxt_lo) || (byte_i > state_i.nxt_hi));
  assign as_lead   = (state_i.seq_len == LEN_NONE) || mismatch;
  assign taken_inc = state_i.taken + 2'd1;
  assign accum_inc = {state_i.accum[14:0], byte_i[5:0]};
  assign complete  = (taken_inc == 2'd0) || ({1'b0, taken_inc} >= state_i.seq_len);

  always_comb begin
    nxt = state_i;
    res = '{count: 2'd0, unit0: 16'd0, unit1: 16'd0};

    if (as_lead) begin
      // A broken prefix gives one replacement, then the byte starts afresh.
      if (mismatch) begin
        res = push_unit(res, REPL_UNIT);
      end
      nxt = STATE_IDLE;
      if (byte_i <= ASCII_TOP) begin
        res = push_unit(res, {8'd0, byte_i});
      end else if (byte_i inside {[LEAD2_LO:LEAD2_HI]}) begin
        nxt.seq_len = LEN_TWO;
        nxt.taken   = 2'd1;
        nxt.accum   = {16'd0, byte_i[4:0]};
      end else if (byte_i inside {[LEAD3_LO:LEAD3_HI]}) begin
        nxt.seq_len = LEN_THR;
        nxt.taken   = 2'd1;
        nxt.accum   = {17'd0, byte_i[3:0]};
        if (byte_i == LEAD_E0) nxt.nxt_lo = E0_CONT_LO;
        if (byte_i == LEAD_ED) nxt.nxt_hi = ED_CONT_HI;
      end else if (byte_i inside {[LEAD4_LO:LEAD4_HI]}) begin
        nxt.seq_len = LEN_FOUR;
        nxt.taken   = 2'd1;
        nxt.accum   = {18'd0, byte_i[2:0]};
        if (byte_i == LEAD_F0) nxt.nxt_lo = F0_CONT_LO;
        if (byte_i == LEAD_F4) nxt.nxt_hi = F4_CONT_HI;
      end else begin
        res = push_unit(res, REPL_UNIT);
      end
    end else begin
      // Continuation byte: gather six more bits.
      nxt.accum  = accum_inc;
      nxt.taken  = taken_inc;
      nxt.nxt_lo = CONT_LO;
      nxt.nxt_hi = CONT_HI;
      if (complete) begin
        if (accum_inc[20:16] != 5'd0) begin
          res = push_unit(res, REPL_UNIT);
        end else begin
          res = push_unit(res, accum_inc[15:0]);
        end
        nxt = STATE_IDLE;
      end
    end

    // The end of a text closes any unfinished sequence.
    if (last_i && (nxt.seq_len != LEN_NONE)) begin
      res = push_unit(res, REPL_UNIT);
      nxt = STATE_IDLE;
    end
  end

  assign state_o = nxt;
  assign res_o   = res;

endmodule

`default_nettype wire

FILE: hdl/utd_checker.sv
// ----------------------------------------------------------------------------
// UTF-8 decoder port checker
// Concurrent checks on the decoder's ports, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module utd_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [15:0] m_axis_tdata,
  input wire logic        m_axis_tuser,
  input wire logic        m_axis_tlast
);
  import utd_pkg::*;

  // Once reset has been seen at an edge, no output beat is offered on the next one.
  a_reset_idle: assert property (@(posedge clk_i) !rst_ni |=> !m_axis_tvalid)
    else $error("output valid after reset");

  // The end of a text is always the last unit of its byte.
  a_end_is_run_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast) |-> m_axis_tuser)
    else $error("text end without run end");

  // When a byte yields two units, the first is always a replacement.
  a_first_is_repl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == REPL_UNIT))
    else $error("first of two units is not a replacement");

  // A stalled beat stays offered.
  a_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
    else $error("output valid dropped while stalled");

endmodule

bind utf8_to_utf16_validating_decoder utd_checker u_utd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
